[src/acm_pkg.sv]
// Shared constants for the accumulator machine: operation codes, status codes and sizes.
`timescale 1ns / 1ps
`default_nettype none
package acm_pkg;

   // Program store geometry.
   localparam int unsigned PROG_DEPTH = 4096;
   localparam int unsigned PROG_AW    = 12;
   localparam int unsigned PC_W       = 13;

   // Variable file geometry: 26 letters and one scratch slot.
   localparam int unsigned SLOT_COUNT = 27;
   localparam int unsigned SLOT_AW    = 5;

   // Operand characters.
   localparam logic [7:0] FIRST_LETTER = 8'h41;
   localparam logic [7:0] LAST_SLOT    = 8'h5B;
   localparam logic [7:0] IMM_MARK     = 8'h3D;
   localparam logic [4:0] SCRATCH_SLOT = 5'd26;

   // Operation codes.
   localparam logic [7:0] OP_DECL   = 8'd0;
   localparam logic [7:0] OP_LOAD   = 8'd1;
   localparam logic [7:0] OP_STORE  = 8'd2;
   localparam logic [7:0] OP_LABEL  = 8'd3;
   localparam logic [7:0] OP_ADD    = 8'd4;
   localparam logic [7:0] OP_SUB    = 8'd5;
   localparam logic [7:0] OP_MUL    = 8'd6;
   localparam logic [7:0] OP_DIV    = 8'd7;
   localparam logic [7:0] OP_BRNEG  = 8'd8;
   localparam logic [7:0] OP_BRZERO = 8'd9;
   localparam logic [7:0] OP_BRPOS  = 8'd10;
   localparam logic [7:0] OP_JUMP   = 8'd11;
   localparam logic [7:0] OP_PRINT  = 8'd12;
   localparam logic [7:0] OP_END    = 8'd13;

   // Halt status codes.
   localparam logic [2:0] ST_RUN      = 3'd0;
   localparam logic [2:0] ST_ENDED    = 3'd1;
   localparam logic [2:0] ST_NO_LABEL = 3'd2;
   localparam logic [2:0] ST_BAD_VAR  = 3'd3;
   localparam logic [2:0] ST_DIV_ZERO = 3'd4;
   localparam logic [2:0] ST_PAST_END = 3'd5;

   // One program word.
   typedef struct packed {
      logic [7:0] code;
      logic [7:0] argument;
      logic [7:0] value;
   } prog_word_type;

endpackage
`default_nettype wire

[src/accumulator_machine_step_top.sv]
// Top level of the accumulator machine: program store, variable file and bit-serial datapath.
`timescale 1ns / 1ps
`default_nettype none
// A load word writes one program word, then the block places the answer before it takes the
// next word. A step word fetches the instruction at the program counter and decodes it; load,
// add, subtract, multiply and divide then fetch their operand, and a halted or past-the-end
// step goes straight to the answer. Add, subtract, multiply and divide (but for a divide by
// zero) pass through a serial unit, one operand bit per cycle. A taken branch walks the
// program store from word zero, one word at a time through the single read port, until it
// finds the label or passes the program length. One word is worked at a time; a finished
// answer waits in the output register while the next word is taken.
module accumulator_machine_step_top
   import acm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_type,
   input  wire logic [11:0]        req_load_address,
   input  wire logic [7:0]         req_load_code,
   input  wire logic [7:0]         req_load_argument,
   input  wire logic [7:0]         req_load_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_print_valid,
   output logic signed [31:0]      rsp_print_value,
   output logic [12:0]             rsp_next_pc,
   output logic [2:0]              rsp_status,
   input  wire logic               csr_write_enable,
   input  wire logic [12:0]        csr_write_data
);

   typedef enum logic [2:0] {
      IDLE, DECODE, OPRD, SERIAL, FIN, SRCH, SCHK, RESP
   } state_type;

   state_type state_ff, state_in;

   logic [31:0]       acc_ff, acc_in;
   logic [PC_W-1:0]   pc_ff, pc_in;
   logic [2:0]        halt_ff, halt_in;
   logic [PC_W-1:0]   len_ff, len_in;
   logic              prt_ff, prt_in;
   logic [2:0]        opk_ff, opk_in;
   logic              imm_ff, imm_in;
   logic [7:0]        val_ff, val_in;
   logic [7:0]        lab_ff, lab_in;
   logic [PC_W-1:0]   k_ff, k_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [31:0]       sa_ff, sa_in;
   logic [31:0]       sb_ff, sb_in;
   logic [31:0]       sp_ff, sp_in;
   logic              c_ff, c_in;
   logic              neg_ff, neg_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_pv_ff, rsp_pv_in;
   logic [31:0]       rsp_val_ff, rsp_val_in;
   logic [PC_W-1:0]   rsp_pc_ff, rsp_pc_in;
   logic [2:0]        rsp_st_ff, rsp_st_in;

   // Program store and its registered read.
   logic [23:0]        pm_mem [PROG_DEPTH];
   prog_word_type      pm_rd_ff;
   logic [PROG_AW-1:0] pm_ra;
   logic               pm_we;

   // Variable file with a valid bit per slot so that reset reads as zero.
   logic [31:0]        vf_mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] vf_vld_ff;
   logic [31:0]        vf_rd_ff;
   logic               vf_rv_ff;
   logic               vf_we;
   logic [SLOT_AW-1:0] vf_wa;
   logic [31:0]        vf_wd;
   logic [SLOT_AW-1:0] vf_ra;

   // Decode helpers.
   prog_word_type   dw;
   logic            d_imm;
   logic [7:0]      d_arg;
   logic [7:0]      d_off;
   logic            d_var_ok;
   logic            d_needs;
   logic [SLOT_AW-1:0] d_slot;
   logic            d_take;
   logic [PC_W-1:0] eff_len;
   logic [31:0]     operand;
   logic            s_bit;
   logic [31:0]     s_rem;
   logic            s_q;
   logic [PC_W-1:0] k_next;

   assign req_ready       = (state_ff == IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_print_valid = rsp_pv_ff;
   assign rsp_print_value = rsp_val_ff;
   assign rsp_next_pc     = rsp_pc_ff;
   assign rsp_status      = rsp_st_ff;

   assign pm_we   = req_valid && req_ready && !req_type;
   assign eff_len = (len_ff > PC_W'(PROG_DEPTH)) ? PC_W'(PROG_DEPTH) : len_ff;
   assign k_next  = k_ff + 1'b1;

   // Word decode from the fetched instruction.
   assign dw       = pm_rd_ff;
   assign d_imm    = (dw.argument == IMM_MARK);
   assign d_arg    = d_imm ? LAST_SLOT : dw.argument;
   assign d_off    = d_arg - FIRST_LETTER;
   assign d_var_ok = (d_arg >= FIRST_LETTER) && (d_arg <= LAST_SLOT);
   assign d_slot   = d_var_ok ? d_off[SLOT_AW-1:0] : '0;
   assign d_needs  = (dw.code <= OP_DIV) && (dw.code != OP_LABEL);

   always_comb begin
      case (dw.code)
         OP_BRNEG:  d_take = acc_ff[31];
         OP_BRZERO: d_take = (acc_ff == '0);
         OP_BRPOS:  d_take = (acc_ff != '0) && !acc_ff[31];
         OP_JUMP:   d_take = 1'b1;
         default:   d_take = 1'b0;
      endcase
   end

   // Operand after the variable read; the scratch value bypasses the file.
   assign operand = imm_ff ? {24'd0, val_ff} : (vf_rv_ff ? vf_rd_ff : '0);

   // Serial unit: one bit of the add, one step of the divide.
   assign s_bit = sa_ff[0] ^ sb_ff[0] ^ c_ff;
   assign s_rem = {sp_ff[30:0], sa_ff[31]};
   assign s_q   = (s_rem >= sb_ff);

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      acc_in = acc_ff;   pc_in = pc_ff;     halt_in = halt_ff;
      len_in = csr_write_enable ? csr_write_data : len_ff;
      prt_in = prt_ff;   opk_in = opk_ff;   imm_in = imm_ff;   val_in = val_ff;
      lab_in = lab_ff;   k_in = k_ff;       cnt_in = cnt_ff;
      sa_in = sa_ff;     sb_in = sb_ff;     sp_in = sp_ff;
      c_in = c_ff;       neg_in = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pv_in = rsp_pv_ff; rsp_val_in = rsp_val_ff;
      rsp_pc_in = rsp_pc_ff; rsp_st_in = rsp_st_ff;
      pm_ra = pc_ff[PROG_AW-1:0];
      vf_we = 1'b0; vf_wa = '0; vf_wd = '0; vf_ra = '0;

      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               prt_in = 1'b0;
               if (!req_type || halt_ff != ST_RUN) begin
                  state_in = RESP;
               end else if (pc_ff >= eff_len) begin
                  halt_in  = ST_PAST_END;
                  state_in = RESP;
               end else begin
                  state_in = DECODE;
               end
            end
         end

         DECODE: begin
            state_in = RESP;
            if (d_needs && !d_var_ok) begin
               halt_in = ST_BAD_VAR;
            end else begin
               // The immediate marker always lands in the scratch slot first.
               if (d_imm) begin
                  vf_we = 1'b1;
                  vf_wa = SCRATCH_SLOT;
                  vf_wd = {24'd0, dw.value};
               end
               case (dw.code)
                  OP_DECL: begin
                     vf_we = 1'b1; vf_wa = d_slot; vf_wd = {24'd0, dw.value};
                     pc_in = pc_ff + 1'b1;
                  end
                  OP_STORE: begin
                     vf_we = 1'b1; vf_wa = d_slot; vf_wd = acc_ff;
                     pc_in = pc_ff + 1'b1;
                  end
                  OP_LOAD, OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                     vf_ra    = d_slot;
                     opk_in   = dw.code[2:0];
                     imm_in   = d_imm;
                     val_in   = dw.value;
                     state_in = OPRD;
                  end
                  OP_BRNEG, OP_BRZERO, OP_BRPOS, OP_JUMP: begin
                     if (d_take) begin
                        lab_in   = d_arg;
                        k_in     = '0;
                        state_in = SRCH;
                     end else begin
                        pc_in = pc_ff + 1'b1;
                     end
                  end
                  OP_PRINT: begin
                     prt_in = 1'b1;
                     pc_in  = pc_ff + 1'b1;
                  end
                  OP_END: begin
                     halt_in = ST_ENDED;
                  end
                  default: begin
                     pc_in = pc_ff + 1'b1;
                  end
               endcase
            end
         end

         OPRD: begin
            cnt_in   = '0;
            state_in = SERIAL;
            case (opk_ff)
               OP_LOAD[2:0]: begin
                  acc_in   = operand;
                  pc_in    = pc_ff + 1'b1;
                  state_in = RESP;
               end
               OP_ADD[2:0]: begin
                  sa_in = acc_ff; sb_in = operand; c_in = 1'b0;
               end
               OP_SUB[2:0]: begin
                  sa_in = acc_ff; sb_in = ~operand; c_in = 1'b1;
               end
               OP_MUL[2:0]: begin
                  sa_in = acc_ff; sb_in = operand; sp_in = '0;
               end
               OP_DIV[2:0]: begin
                  if (operand == '0) begin
                     halt_in  = ST_DIV_ZERO;
                     state_in = RESP;
                  end else begin
                     sa_in  = acc_ff[31] ? (32'd0 - acc_ff) : acc_ff;
                     sb_in  = operand[31] ? (32'd0 - operand) : operand;
                     sp_in  = '0;
                     neg_in = acc_ff[31] ^ operand[31];
                  end
               end
               default: begin
                  pc_in    = pc_ff + 1'b1;
                  state_in = RESP;
               end
            endcase
         end

         SERIAL: begin
            case (opk_ff)
               OP_MUL[2:0]: begin
                  sp_in = sp_ff + (sb_ff[0] ? sa_ff : 32'd0);
                  sa_in = {sa_ff[30:0], 1'b0};
                  sb_in = {1'b0, sb_ff[31:1]};
               end
               OP_DIV[2:0]: begin
                  sp_in = s_q ? (s_rem - sb_ff) : s_rem;
                  sa_in = {sa_ff[30:0], s_q};
               end
               default: begin
                  sa_in = {s_bit, sa_ff[31:1]};
                  sb_in = {1'b0, sb_ff[31:1]};
                  c_in  = (sa_ff[0] & sb_ff[0]) | (c_ff & (sa_ff[0] ^ sb_ff[0]));
               end
            endcase
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'd31) begin
               state_in = FIN;
            end
         end

         FIN: begin
            case (opk_ff)
               OP_MUL[2:0]: acc_in = sp_ff;
               OP_DIV[2:0]: acc_in = neg_ff ? (32'd0 - sa_ff) : sa_ff;
               default:     acc_in = sa_ff;
            endcase
            pc_in    = pc_ff + 1'b1;
            state_in = RESP;
         end

         SRCH: begin
            pm_ra    = k_ff[PROG_AW-1:0];
            state_in = SCHK;
         end

         SCHK: begin
            if (dw.code == OP_LABEL && dw.argument == lab_ff) begin
               pc_in    = k_ff;
               state_in = RESP;
            end else if (k_next >= eff_len) begin
               halt_in  = ST_NO_LABEL;
               state_in = RESP;
            end else begin
               k_in     = k_next;
               state_in = SRCH;
            end
         end

         RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_pv_in    = prt_ff;
               rsp_val_in   = prt_ff ? acc_ff : 32'd0;
               rsp_pc_in    = pc_ff;
               rsp_st_in    = halt_ff;
               state_in     = IDLE;
            end
         end

         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         acc_ff       <= '0;
         pc_ff        <= '0;
         halt_ff      <= ST_RUN;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         pc_ff        <= pc_in;
         halt_ff      <= halt_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prt_ff     <= prt_in;
      opk_ff     <= opk_in;
      imm_ff     <= imm_in;
      val_ff     <= val_in;
      lab_ff     <= lab_in;
      k_ff       <= k_in;
      cnt_ff     <= cnt_in;
      sa_ff      <= sa_in;
      sb_ff      <= sb_in;
      sp_ff      <= sp_in;
      c_ff       <= c_in;
      neg_ff     <= neg_in;
      rsp_pv_ff  <= rsp_pv_in;
      rsp_val_ff <= rsp_val_in;
      rsp_pc_ff  <= rsp_pc_in;
      rsp_st_ff  <= rsp_st_in;
   end

   // Program store: one write port for loads, one registered read port.
   always_ff @(posedge clock) begin
      if (pm_we) begin
         pm_mem[req_load_address] <= {req_load_code, req_load_argument, req_load_value};
      end
      pm_rd_ff <= pm_mem[pm_ra];
   end

   // Variable file storage and registered read.
   always_ff @(posedge clock) begin
      if (vf_we) begin
         vf_mem[vf_wa] <= vf_wd;
      end
      vf_rd_ff <= vf_mem[vf_ra];
      vf_rv_ff <= vf_vld_ff[vf_ra];
   end

   // Slot valid bits, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         vf_vld_ff <= '0;
      end else if (vf_we) begin
         vf_vld_ff[vf_wa] <= 1'b1;
      end
   end

endmodule
`default_nettype wire

[src/acm_checker.sv]
// Port-level checks for the accumulator machine and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
module acm_checker
   import acm_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_print_valid,
   input wire logic [31:0] rsp_print_value,
   input wire logic [12:0] rsp_next_pc,
   input wire logic [2:0]  rsp_status
);

   // A stalled result word holds its next program counter and status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next_pc) && $stable(rsp_status))
      else $error("result word changed while stalled");

   // Only a print word carries a nonzero value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_print_valid |-> rsp_print_value == 32'd0)
      else $error("value shown without print");

   // A print always comes from a running machine.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_print_valid |-> rsp_status == ST_RUN)
      else $error("print reported with halted status");

   // The program counter never passes the store depth.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_next_pc <= 13'(PROG_DEPTH))
      else $error("program counter beyond store");

endmodule

bind accumulator_machine_step_top acm_checker u_acm_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_print_valid (rsp_print_valid),
   .rsp_print_value (rsp_print_value),
   .rsp_next_pc     (rsp_next_pc),
   .rsp_status      (rsp_status)
);
`default_nettype wire

[verif/tb_accumulator_machine_step_top.sv]
// Self-checking testbench for the accumulator machine top level.
`timescale 1ns / 1ps
module tb_accumulator_machine_step_top;
   import acm_pkg::*;

   // Label byte of word zero, the anchor every wrap-around jump returns to.
   localparam logic [7:0] START_MARK = 8'h24;
   // Words 0..KEPT_WORDS-1 are always written, so fetch and label search stay defined.
   localparam int KEPT_WORDS = 64;
   localparam int QUIET_LIMIT = 40000;

   typedef struct {
      logic        print_valid;
      logic [31:0] print_value;
      logic [12:0] next_pc;
      logic [2:0]  status;
   } answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_type = 1'b0;
   logic [11:0] req_load_address = '0;
   logic [7:0]  req_load_code = '0;
   logic [7:0]  req_load_argument = '0;
   logic [7:0]  req_load_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_print_valid;
   logic signed [31:0] rsp_print_value;
   logic [12:0] rsp_next_pc;
   logic [2:0]  rsp_status;
   logic        csr_write_enable = 1'b0;
   logic [12:0] csr_write_data = '0;

   // Shadow copy of the machine state.
   prog_word_type store_copy [PROG_DEPTH];
   bit            word_written [PROG_DEPTH];
   logic [31:0]   var_copy [SLOT_COUNT];
   logic [31:0]   acc_copy;
   logic [12:0]   pc_copy;
   logic [2:0]    halt_copy;
   logic [12:0]   length_copy;

   answer_type answers_due [$];
   int failures = 0;
   int quiet_cycles = 0;
   int idle_pct = 0;
   int stall_pct = 0;

   accumulator_machine_step_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_load_address(req_load_address), .req_load_code(req_load_code),
      .req_load_argument(req_load_argument), .req_load_value(req_load_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_print_valid(rsp_print_valid), .rsp_print_value(rsp_print_value),
      .rsp_next_pc(rsp_next_pc), .rsp_status(rsp_status),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int covered_words();
      return (length_copy > PROG_DEPTH) ? PROG_DEPTH : int'(length_copy);
   endfunction

   // Search for the first label word; safe is cleared if an unwritten word would be read.
   function automatic bit seek_label(input logic [7:0] mark, output int where, output bit safe);
      safe = 1'b1;
      where = 0;
      for (int k = 0; k < covered_words(); k++) begin
         if (!word_written[k]) begin
            safe = 1'b0;
            return 1'b0;
         end
         if (store_copy[k].code == OP_LABEL && store_copy[k].argument == mark) begin
            where = k;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic logic [31:0] divide_trunc(input logic [31:0] num, input logic [31:0] den);
      logic [31:0] nmag;
      logic [31:0] dmag;
      logic [31:0] q;
      nmag = num[31] ? -num : num;
      dmag = den[31] ? -den : den;
      q = nmag / dmag;
      return (num[31] != den[31]) ? -q : q;
   endfunction

   function automatic bit branch_taken(input logic [7:0] code);
      case (code)
         OP_BRNEG:  return acc_copy[31];
         OP_BRZERO: return acc_copy == 0;
         OP_BRPOS:  return acc_copy != 0 && !acc_copy[31];
         OP_JUMP:   return 1'b1;
         default:   return 1'b0;
      endcase
   endfunction

   // Advance the shadow machine by one word and form the expected answer.
   task automatic advance_machine(input bit typ, input logic [11:0] addr,
                                  input prog_word_type word, output answer_type ans);
      prog_word_type w;
      logic [7:0] arg;
      logic [4:0] slot;
      int target;
      bit safe;
      bit printed;
      bit halted;
      printed = 1'b0;
      halted = 1'b0;
      slot = '0;
      if (!typ) begin
         store_copy[addr] = word;
         word_written[addr] = 1'b1;
      end else if (halt_copy == ST_RUN) begin
         if (pc_copy >= covered_words()) begin
            halt_copy = ST_PAST_END;
         end else begin
            w = store_copy[pc_copy];
            arg = w.argument;
            if (arg == IMM_MARK) begin
               var_copy[SCRATCH_SLOT] = {24'd0, w.value};
               arg = LAST_SLOT;
            end
            if (w.code <= OP_DIV && w.code != OP_LABEL) begin
               if (arg < FIRST_LETTER || arg > LAST_SLOT) begin
                  halt_copy = ST_BAD_VAR;
                  halted = 1'b1;
               end else begin
                  slot = 5'(arg - FIRST_LETTER);
               end
            end
            if (!halted) begin
               case (w.code)
                  OP_DECL:  var_copy[slot] = {24'd0, w.value};
                  OP_LOAD:  acc_copy = var_copy[slot];
                  OP_STORE: var_copy[slot] = acc_copy;
                  OP_ADD:   acc_copy = acc_copy + var_copy[slot];
                  OP_SUB:   acc_copy = acc_copy - var_copy[slot];
                  OP_MUL:   acc_copy = acc_copy * var_copy[slot];
                  OP_DIV: begin
                     if (var_copy[slot] == 0) begin
                        halt_copy = ST_DIV_ZERO;
                        halted = 1'b1;
                     end else begin
                        acc_copy = divide_trunc(acc_copy, var_copy[slot]);
                     end
                  end
                  OP_PRINT: printed = 1'b1;
                  OP_END: begin
                     halt_copy = ST_ENDED;
                     halted = 1'b1;
                  end
                  default: ;
               endcase
            end
            if (!halted) begin
               if (branch_taken(w.code)) begin
                  if (seek_label(arg, target, safe)) pc_copy = 13'(target);
                  else halt_copy = ST_NO_LABEL;
               end else begin
                  pc_copy = pc_copy + 1;
               end
            end
         end
      end
      ans.print_valid = printed;
      ans.print_value = printed ? acc_copy : 32'd0;
      ans.next_pc = pc_copy;
      ans.status = halt_copy;
   endtask

   // Present one word on the request channel and record its expected answer.
   task automatic send_word(input bit typ, input logic [11:0] addr, input prog_word_type word);
      answer_type ans;
      @(negedge clock);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < idle_pct) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= typ;
      req_load_address <= addr;
      req_load_code <= word.code;
      req_load_argument <= word.argument;
      req_load_value <= word.value;
      do @(posedge clock); while (!req_ready);
      advance_machine(typ, addr, word, ans);
      answers_due.push_back(ans);
   endtask

   task automatic load_word(input logic [11:0] addr, input logic [7:0] code,
                            input logic [7:0] arg, input logic [7:0] val);
      send_word(1'b0, addr, '{code: code, argument: arg, value: val});
   endtask

   // A step word carries random, ignored payload so those bits toggle too.
   task automatic step_word();
      send_word(1'b1, 12'($urandom), prog_word_type'($urandom));
   endtask

   // Write the word at the program counter and execute it.
   task automatic run_word(input logic [7:0] code, input logic [7:0] arg, input logic [7:0] val);
      while (pc_copy < 2 && halt_copy == ST_RUN) step_word();
      load_word(12'(pc_copy), code, arg, val);
      step_word();
   endtask

   // Drop valid and wait until every expected answer has arrived.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_length(input logic [12:0] len);
      drain();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= len;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      length_copy = len;
   endtask

   // Bring the program counter back to word zero before a length change.
   task automatic return_to_start();
      if (pc_copy >= 2) run_word(OP_JUMP, START_MARK, 8'($urandom));
   endtask

   // Pick a word for the current program counter that keeps the machine running.
   task automatic pick_running_word(output logic [7:0] code, output logic [7:0] arg,
                                    output logic [7:0] val);
      int roll;
      int pick;
      int where;
      bit safe;
      logic [7:0] mark;
      logic [31:0] divisor;
      roll = $urandom_range(99);
      val = 8'($urandom);
      arg = 8'($urandom);
      if (roll < 45) begin
         pick = $urandom_range(6);
         code = (pick >= 3) ? 8'(pick + 1) : 8'(pick);
         pick = $urandom_range(27);
         arg = (pick == 27) ? IMM_MARK : FIRST_LETTER + 8'(pick);
         if (code == OP_DIV) begin
            divisor = (arg == IMM_MARK) ? {24'd0, val} : var_copy[arg - FIRST_LETTER];
            if (divisor == 0) begin
               if (arg == IMM_MARK) val = 8'd1;
               else code = OP_ADD;
            end
         end
      end else if (roll < 55) begin
         code = OP_LABEL;
      end else if (roll < 75) begin
         code = 8'($urandom_range(OP_BRNEG, OP_JUMP));
         if ($urandom_range(3) == 0) arg = START_MARK;
         mark = (arg == IMM_MARK) ? LAST_SLOT : arg;
         if (branch_taken(code) && !(seek_label(mark, where, safe) && safe)) arg = START_MARK;
      end else if (roll < 85) begin
         code = OP_PRINT;
      end else begin
         code = 8'($urandom_range(OP_END + 1, 255));
      end
   endtask

   // One step of the running program; past the two anchor words, the word under the counter is refreshed first.
   task automatic step_running();
      int span;
      logic [7:0] code;
      logic [7:0] arg;
      logic [7:0] val;
      span = (covered_words() < KEPT_WORDS) ? covered_words() : KEPT_WORDS;
      if (pc_copy < 2) begin
         step_word();
      end else if (pc_copy >= span - 1) begin
         run_word(OP_JUMP, START_MARK, 8'($urandom));
      end else begin
         pick_running_word(code, arg, val);
         run_word(code, arg, val);
      end
   endtask

   // Fill the kept words: two anchor labels, then random content; then write the last store word and set the length.
   task automatic test_program_fill();
      load_word(12'd0, OP_LABEL, START_MARK, 8'd0);
      load_word(12'd1, OP_LABEL, LAST_SLOT, 8'd0);
      for (int k = 2; k < KEPT_WORDS; k++) load_word(12'(k), 8'($urandom), 8'($urandom),
                                                    8'($urandom));
      load_word(12'hFFF, 8'hFF, 8'hFF, 8'hFF);
      write_length(13'(KEPT_WORDS));
   endtask

   // Every operation but end, an unknown code, wrap-around arithmetic and the immediate operand.
   task automatic test_directed();
      run_word(OP_DECL, "A", 8'd128);
      run_word(OP_LOAD, "A", 8'd0);
      repeat (3) run_word(OP_MUL, "A", 8'd0);
      run_word(OP_DECL, "B", 8'd8);
      run_word(OP_MUL, "B", 8'd0);
      run_word(OP_PRINT, "Q", 8'd0);
      run_word(OP_STORE, "M", 8'd0);
      run_word(OP_BRNEG, START_MARK, 8'd0);
      run_word(OP_LOAD, IMM_MARK, 8'd0);
      run_word(OP_BRZERO, IMM_MARK, 8'd0);
      run_word(OP_SUB, IMM_MARK, 8'd1);
      run_word(OP_STORE, "N", 8'd0);
      run_word(OP_LOAD, "M", 8'd0);
      run_word(OP_DIV, "N", 8'd0);
      run_word(OP_PRINT, IMM_MARK, 8'd255);
      run_word(OP_BRPOS, START_MARK, 8'd0);
      run_word(OP_DIV, IMM_MARK, 8'd7);
      run_word(OP_ADD, LAST_SLOT, 8'd0);
      run_word(OP_LABEL, "Q", 8'd0);
      run_word(8'hFF, 8'hFF, 8'hFF);
      run_word(OP_BRPOS, START_MARK, 8'd0);
      run_word(OP_JUMP, START_MARK, 8'd0);
   endtask

   // Random running program under one idle and stall pattern and one program length.
   task automatic test_random(input int idle, input int stall, input logic [12:0] len);
      return_to_start();
      write_length(len);
      idle_pct = idle;
      stall_pct = stall;
      repeat (140) begin
         if ($urandom_range(99) < 10) begin
            logic [11:0] addr;
            addr = 12'($urandom);
            if (addr < 2 || addr == pc_copy[11:0]) addr = 12'hFFE;
            load_word(addr, 8'($urandom), 8'($urandom), 8'($urandom));
         end
         step_running();
      end
   endtask

   // The halt is permanent, so one halting case is chosen per run, then it is probed.
   task automatic test_halt();
      int kind;
      int where;
      bit safe;
      logic [7:0] mark;
      idle_pct = 10;
      stall_pct = 10;
      return_to_start();
      write_length(13'(KEPT_WORDS));
      kind = $urandom_range(1, 5);
      case (kind)
         ST_ENDED:    run_word(OP_END, 8'($urandom), 8'($urandom));
         ST_BAD_VAR:  run_word(OP_DECL, "a", 8'd5);
         ST_DIV_ZERO: run_word(OP_DIV, IMM_MARK, 8'd0);
         ST_NO_LABEL: begin
            do mark = 8'($urandom);
            while (mark == IMM_MARK || seek_label(mark, where, safe));
            run_word(OP_JUMP, mark, 8'd0);
         end
         default: begin
            write_length(13'd0);
            step_word();
         end
      endcase
      repeat (3) begin
         step_word();
         load_word(12'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end
   endtask

   // Receiver stalls are drawn each cycle.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Answer checking and the inactivity watchdog.
   always @(posedge clock) begin
      answer_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               $error("answer with nothing expected");
               failures++;
            end else begin
               want = answers_due.pop_front();
               if (rsp_print_valid !== want.print_valid) begin
                  $error("print_valid expected %0d actual %0d", want.print_valid,
                         rsp_print_valid);
                  failures++;
               end
               if (rsp_print_value !== want.print_value) begin
                  $error("print_value expected %0d actual %0d", $signed(want.print_value),
                         rsp_print_value);
                  failures++;
               end
               if (rsp_next_pc !== want.next_pc) begin
                  $error("next_pc expected %0d actual %0d", want.next_pc, rsp_next_pc);
                  failures++;
               end
               if (rsp_status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_status);
                  failures++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_accumulator_machine_step_top failed");
            $finish;
         end
      end
   end

   initial begin
      for (int k = 0; k < SLOT_COUNT; k++) var_copy[k] = '0;
      acc_copy = '0;
      pc_copy = '0;
      halt_copy = ST_RUN;
      length_copy = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_program_fill();
      test_directed();
      test_random(0, 0, 13'(KEPT_WORDS));
      test_random(88, 0, 13'(PROG_DEPTH));
      test_random(0, 88, 13'd17);
      test_random(24, 24, 13'($urandom_range(3, KEPT_WORDS)));
      test_halt();
      drain();
      repeat (60) @(posedge clock);
      if (failures == 0) $display("tb_accumulator_machine_step_top passed");
      else $display("tb_accumulator_machine_step_top failed");
      $finish;
   end

endmodule

[accumulator_machine_step_top.f]
src/acm_pkg.sv
src/accumulator_machine_step_top.sv
src/acm_checker.sv
verif/tb_accumulator_machine_step_top.sv
